### rtl/gld_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// gld_pkg: shared types and constants
// Status codes, configuration register indexes and channel payload types.
// ---------------------------------------------------------------------------
package gld_pkg;

    typedef enum logic [2:0] {
        ST_BYTE_TAKEN = 3'd0,
        ST_PIXEL      = 3'd1,
        ST_NEED_DATA  = 3'd2,
        ST_DONE       = 3'd3,
        ST_ERROR      = 3'd4,
        ST_REJECTED   = 3'd5
    } status_t;

    localparam logic [2:0] REG_MIN_CODE_SIZE = 3'd0;
    localparam logic [2:0] REG_IMAGE_WIDTH   = 3'd1;
    localparam logic [2:0] REG_IMAGE_HEIGHT  = 3'd2;
    localparam logic [2:0] REG_ROW_STRIDE    = 3'd3;
    localparam logic [2:0] REG_INTERLACED    = 3'd4;

    localparam logic OP_PUSH  = 1'b0;
    localparam logic OP_DRAIN = 1'b1;

    localparam logic [1:0] FIN_RUNNING = 2'd0;
    localparam logic [1:0] FIN_DONE    = 2'd1;
    localparam logic [1:0] FIN_ERROR   = 2'd2;

    typedef struct packed {
        logic       op;
        logic [7:0] data_byte;
    } in_item_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [7:0]  pixel_value;
        logic [15:0] pixel_row;
        logic [15:0] pixel_column;
        logic [33:0] byte_offset;
        logic        is_last;
    } out_item_t;

    typedef struct packed {
        logic [2:0]  index;
        logic [17:0] data;
    } cfg_item_t;

endpackage

### rtl/gld_stream_if.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// gld_stream_if: valid/ready channel
// Carries one payload item per handshake.
// ---------------------------------------------------------------------------
interface gld_stream_if #(
    parameter int W = 9
);
    logic         valid;
    logic         ready;
    logic [W-1:0] payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

### rtl/gld_ram.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// gld_ram: generic single-port RAM
// One write or one read per cycle, registered read data.
// ---------------------------------------------------------------------------
module gld_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // Write or read one entry
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule

### rtl/gld_placer.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// gld_placer: pixel placement
// Tracks row and column, plain or four-pass interlace order, and the
// byte offset row*stride+column through a registered multiply.
// ---------------------------------------------------------------------------
module gld_placer
    import gld_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        advance,
    input  logic [15:0] image_width,
    input  logic [15:0] image_height,
    input  logic [17:0] row_stride,
    input  logic        interlaced,
    output logic [15:0] row,
    output logic [15:0] column,
    output logic [33:0] offset
);
    logic [15:0] row_reg, row_next, col_reg, col_next;
    logic [16:0] r8, r4, r2;
    logic [33:0] offset_reg;

    assign r8 = {1'b0, row_reg} + 17'd8;
    assign r4 = {1'b0, row_reg} + 17'd4;
    assign r2 = {1'b0, row_reg} + 17'd2;

    // Pick next row position
    always_comb
    begin
        logic [16:0] nr;
        nr = {1'b0, row_reg} + 17'd1;
        if (interlaced)
        begin
            priority if (row_reg[2:0] == 3'd0)
            begin
                nr = r8;
                if (r8 >= {1'b0, image_height})
                begin
                    nr = 17'd4;
                    if (image_height <= 16'd4) nr = (image_height <= 16'd2) ? 17'd1 : 17'd2;
                end
            end
            else if (row_reg[1:0] == 2'd0)
            begin
                nr = r8;
                if (r8 >= {1'b0, image_height})
                    nr = (image_height <= 16'd2) ? 17'd1 : 17'd2;
            end
            else if (row_reg[0] == 1'b0)
            begin
                nr = r4;
                if (r4 >= {1'b0, image_height}) nr = 17'd1;
            end
            else
            begin
                nr = r2;
            end
        end
        row_next = row_reg;
        col_next = col_reg;
        if (advance)
        begin
            col_next = col_reg + 16'd1;
            if ({1'b0, col_reg} + 17'd1 >= {1'b0, image_width})
            begin
                col_next = '0;
                row_next = nr[15:0];
            end
        end
    end

    // Hold position, refresh offset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg <= '0;
            col_reg <= '0;
        end
        else
        begin
            row_reg <= row_next;
            col_reg <= col_next;
        end
    end

    always_ff @(posedge clk)
    begin
        offset_reg <= {18'd0, row_reg} * {16'd0, row_stride} + {18'd0, col_reg};
    end

    assign row    = row_reg;
    assign column = col_reg;
    assign offset = offset_reg;
endmodule

### rtl/gif_lzw_decoder_unit.sv
`timescale 1ns / 1ps
// Byte pushes and finished answers go from idle straight to the output state; a need
// data answer leaves fetch; stacked pixels pass the pop states; a decoding drain adds
// check, walk per link and root. The next item is taken the cycle after the result is taken.
// One item in flight; the dictionary walk on the shared RAM port sets the rate.
// Reset clears control state; dictionary and stack RAMs are undefined until written.
// ---------------------------------------------------------------------------
// gif_lzw_decoder_unit: GIF LZW decoder top level
// Bit collection, code decode sequencer, dictionary and stack RAMs, placement.
// ---------------------------------------------------------------------------
module gif_lzw_decoder_unit
    import gld_pkg::*;
#(
    parameter int DICT_ENTRIES  = 4096,
    parameter int MAX_CODE_BITS = 12
) (
    input  logic clk,
    input  logic rst_n,
    gld_stream_if.sink   in_ch,
    gld_stream_if.source out_ch,
    gld_stream_if.sink   cfg_ch
);
    localparam int DW = $clog2(DICT_ENTRIES);
    localparam int SW = DW + 1;
    localparam int CW = $clog2(MAX_CODE_BITS + 1);

    typedef enum logic [3:0] {
        S_IDLE, S_FETCH, S_CHECK, S_WALK_RD, S_WALK_WAIT, S_WALK, S_ROOT,
        S_POP_RD, S_POP_WAIT, S_EMIT, S_OUT
    } state_t;

    state_t state_reg;
    in_item_t  in_item;
    cfg_item_t cfg_item;
    out_item_t out_reg;

    logic [3:0]  mcs_reg;
    logic [15:0] width_reg, height_reg;
    logic [17:0] stride_reg;
    logic        inter_reg;
    logic [23:0] buf_reg;
    logic [4:0]  bcnt_reg;
    logic [CW-1:0] cw_reg;
    logic [DW:0] nfe_reg;
    logic [DW-1:0] prev_reg, code_reg, oc_reg;
    logic [SW-1:0] sc_reg;
    logic [1:0]  fin_reg;
    logic [31:0] done_reg;
    logic        rep_reg, place_adv;
    logic [7:0]  fc_reg;

    logic [3:0]  eff;
    logic [DW:0] clr;
    assign in_item  = in_ch.payload;
    assign cfg_item = cfg_ch.payload;
    assign eff = (mcs_reg < 4'd2) ? 4'd2 : ((mcs_reg > 4'd8) ? 4'd8 : mcs_reg);
    assign clr = (DW+1)'(1) << eff;

    // Dictionary and stack RAMs
    logic          pre_we, suf_we, stk_we;
    logic [DW-1:0] dict_addr;
    logic [DW-1:0] pre_rd;
    logic [7:0]    suf_rd, stk_rd, stk_wd;
    logic [SW-1:0] stk_addr;
    gld_ram #(.WIDTH(DW), .DEPTH(DICT_ENTRIES)) u_prefix (.clk(clk), .we(pre_we),
        .addr(dict_addr), .wdata(prev_reg), .rdata(pre_rd));
    gld_ram #(.WIDTH(8), .DEPTH(DICT_ENTRIES)) u_suffix (.clk(clk), .we(suf_we),
        .addr(dict_addr), .wdata(fc_reg), .rdata(suf_rd));
    gld_ram #(.WIDTH(8), .DEPTH(2*DICT_ENTRIES)) u_stack (.clk(clk), .we(stk_we),
        .addr(stk_addr), .wdata(stk_wd), .rdata(stk_rd));

    // Placement and offset
    logic [15:0] prow, pcol;
    logic [33:0] poff;
    gld_placer u_place (.clk(clk), .rst_n(rst_n), .advance(place_adv),
        .image_width(width_reg), .image_height(height_reg), .row_stride(stride_reg),
        .interlaced(inter_reg), .row(prow), .column(pcol), .offset(poff));

    logic [32:0] total;
    assign total = {1'b0, width_reg} * {1'b0, height_reg};

    // Current code out of the bit buffer
    logic [DW-1:0] cur_code;
    assign cur_code = DW'(buf_reg & ((24'd1 << cw_reg) - 24'd1));

    // RAM controls
    always_comb
    begin
        pre_we = 1'b0; suf_we = 1'b0; stk_we = 1'b0;
        dict_addr = oc_reg; stk_addr = sc_reg; stk_wd = suf_rd;
        unique case (state_reg)
            S_WALK:
            begin
                stk_we = 1'b1;
            end
            S_ROOT:
            begin
                stk_we = 1'b1; stk_wd = fc_reg;
                pre_we = (prev_reg != clr[DW-1:0]) && (nfe_reg < (DW+1)'(DICT_ENTRIES));
                suf_we = pre_we;
                dict_addr = nfe_reg[DW-1:0];
            end
            S_POP_RD, S_POP_WAIT:
            begin
                stk_addr = sc_reg - SW'(1);
            end
            default:
            begin
            end
        endcase
    end

    assign in_ch.ready  = (state_reg == S_IDLE);
    assign cfg_ch.ready = (state_reg == S_IDLE);
    assign out_ch.valid = (state_reg == S_OUT);
    assign out_ch.payload = out_reg;

    // Sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            mcs_reg <= 4'd8; width_reg <= 16'd1; height_reg <= 16'd1;
            stride_reg <= 18'd1; inter_reg <= 1'b0;
            buf_reg <= '0; bcnt_reg <= '0; cw_reg <= CW'(9);
            nfe_reg <= (DW+1)'(258); prev_reg <= DW'(256);
            sc_reg <= '0; fin_reg <= FIN_RUNNING; done_reg <= '0;
            rep_reg <= 1'b0; fc_reg <= '0; code_reg <= '0; oc_reg <= '0;
            out_reg <= '0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (cfg_ch.valid)
                    begin
                        unique case (cfg_item.index)
                            REG_MIN_CODE_SIZE:
                            begin
                                logic [3:0] e;
                                e = (cfg_item.data[3:0] < 4'd2) ? 4'd2 :
                                    ((cfg_item.data[3:0] > 4'd8) ? 4'd8 : cfg_item.data[3:0]);
                                mcs_reg  <= cfg_item.data[3:0];
                                cw_reg   <= CW'(e + 4'd1);
                                nfe_reg  <= ((DW+1)'(1) << e) + (DW+1)'(2);
                                prev_reg <= DW'((DW+1)'(1) << e);
                            end
                            REG_IMAGE_WIDTH:  width_reg  <= cfg_item.data[15:0];
                            REG_IMAGE_HEIGHT: height_reg <= cfg_item.data[15:0];
                            REG_ROW_STRIDE:   stride_reg <= cfg_item.data;
                            REG_INTERLACED:   inter_reg  <= cfg_item.data[0];
                            default:
                            begin
                            end
                        endcase
                    end
                    if (in_ch.valid)
                    begin
                        out_reg <= '0;
                        if (fin_reg == FIN_RUNNING && {1'b0, done_reg} >= total)
                        begin
                            fin_reg <= FIN_DONE; sc_reg <= '0;
                            out_reg.status <= ST_DONE; state_reg <= S_OUT;
                        end
                        else if (fin_reg != FIN_RUNNING)
                        begin
                            out_reg.status <= (fin_reg == FIN_DONE) ? ST_DONE : ST_ERROR;
                            state_reg <= S_OUT;
                        end
                        else if (in_item.op == OP_PUSH)
                        begin
                            if (bcnt_reg > 5'd16)
                                out_reg.status <= ST_REJECTED;
                            else
                            begin
                                buf_reg  <= buf_reg | (24'(in_item.data_byte) << bcnt_reg);
                                bcnt_reg <= bcnt_reg + 5'd8;
                                out_reg.status <= ST_BYTE_TAKEN;
                            end
                            state_reg <= S_OUT;
                        end
                        else
                        begin
                            state_reg <= (sc_reg == '0) ? S_FETCH : S_POP_RD;
                        end
                    end
                end
                S_FETCH:
                begin
                    if (bcnt_reg < 5'(cw_reg))
                    begin
                        out_reg.status <= ST_NEED_DATA; state_reg <= S_OUT;
                    end
                    else
                    begin
                        buf_reg  <= buf_reg >> cw_reg;
                        bcnt_reg <= bcnt_reg - 5'(cw_reg);
                        code_reg <= cur_code;
                        if ({1'b0, cur_code} == clr + (DW+1)'(1))
                        begin
                            fin_reg <= FIN_DONE; out_reg.status <= ST_DONE;
                            state_reg <= S_OUT;
                        end
                        else if ({1'b0, cur_code} == clr)
                        begin
                            cw_reg <= CW'(eff + 4'd1);
                            nfe_reg <= clr + (DW+1)'(2);
                            prev_reg <= clr[DW-1:0];
                        end
                        else
                            state_reg <= S_CHECK;
                    end
                end
                S_CHECK:
                begin
                    rep_reg <= 1'b0; sc_reg <= '0; oc_reg <= code_reg;
                    if ({1'b0, code_reg} > nfe_reg)
                    begin
                        fin_reg <= FIN_ERROR; out_reg.status <= ST_ERROR; state_reg <= S_OUT;
                    end
                    else if ({1'b0, code_reg} == nfe_reg)
                    begin
                        if (prev_reg == clr[DW-1:0])
                        begin
                            fin_reg <= FIN_ERROR; out_reg.status <= ST_ERROR;
                            state_reg <= S_OUT;
                        end
                        else
                        begin
                            rep_reg <= 1'b1; sc_reg <= SW'(1); oc_reg <= prev_reg;
                            state_reg <= S_WALK_RD;
                        end
                    end
                    else
                        state_reg <= S_WALK_RD;
                end
                S_WALK_RD:
                begin
                    if ({1'b0, oc_reg} >= clr + (DW+1)'(2))
                        state_reg <= S_WALK_WAIT;
                    else
                    begin
                        fc_reg <= oc_reg[7:0];
                        state_reg <= S_ROOT;
                    end
                end
                S_WALK_WAIT:
                begin
                    state_reg <= S_WALK;
                end
                S_WALK:
                begin
                    // Stack write of suffix happens combinationally here
                    sc_reg <= sc_reg + SW'(1);
                    oc_reg <= pre_rd;
                    state_reg <= S_WALK_RD;
                end
                S_ROOT:
                begin
                    sc_reg <= sc_reg + SW'(1);
                    state_reg <= S_POP_RD;
                    prev_reg <= code_reg;
                    if (prev_reg != clr[DW-1:0])
                    begin
                        nfe_reg <= nfe_reg + (DW+1)'(1);
                        if (nfe_reg + (DW+1)'(1) >= (DW+1)'(DICT_ENTRIES))
                        begin
                            fin_reg <= FIN_ERROR; sc_reg <= '0;
                            out_reg.status <= ST_ERROR; state_reg <= S_OUT;
                        end
                        else if ((nfe_reg + (DW+1)'(1)) >= ((DW+1)'(1) << cw_reg)
                                 && cw_reg < CW'(MAX_CODE_BITS))
                            cw_reg <= cw_reg + CW'(1);
                    end
                end
                S_POP_RD:
                begin
                    state_reg <= S_POP_WAIT;
                end
                S_POP_WAIT:
                begin
                    state_reg <= S_EMIT;
                end
                S_EMIT:
                begin
                    // KwKwK: bottom stack slot is the first character
                    out_reg.status <= ST_PIXEL;
                    out_reg.pixel_value <= (sc_reg == SW'(1) && rep_reg) ? fc_reg : stk_rd;
                    out_reg.pixel_row <= prow;
                    out_reg.pixel_column <= pcol;
                    out_reg.byte_offset <= poff;
                    done_reg <= done_reg + 32'd1;
                    sc_reg <= sc_reg - SW'(1);
                    if ({1'b0, done_reg} + 33'd1 >= total)
                    begin
                        out_reg.is_last <= 1'b1; fin_reg <= FIN_DONE; sc_reg <= '0;
                    end
                    state_reg <= S_OUT;
                end
                S_OUT:
                begin
                    if (out_ch.ready) state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // Advance placement once per emitted pixel, except for the last pixel of the frame
    assign place_adv = (state_reg == S_EMIT) && ({1'b0, done_reg} + 33'd1 < total);
endmodule

### verif/testbench.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// testbench: GIF LZW decoder unit check
// Builds LZW streams on the fly from a decoder model, drives bytes and drain
// ticks through the input channel with random gaps and output stalls, writes
// the frame registers between phases, and compares every result in order.
// ---------------------------------------------------------------------------
module testbench;
    import gld_pkg::*;

    typedef struct {
        bit        is_cfg;
        cfg_item_t cfg;
        in_item_t  item;
        out_item_t want;
    } stim_entry_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    gld_stream_if #(.W($bits(in_item_t)))  in_if ();
    gld_stream_if #(.W($bits(out_item_t))) out_if ();
    gld_stream_if #(.W($bits(cfg_item_t))) cfg_if ();

    gif_lzw_decoder_unit u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_if),
        .out_ch (out_if),
        .cfg_ch (cfg_if)
    );

    always #1 clk = ~clk;

    // Decoder model state
    logic [3:0]  dec_min_size;
    int          dec_width, dec_height, dec_stride, dec_interlace;
    logic [11:0] dict_prefix [4096];
    logic [7:0]  dict_suffix [4096];
    logic [7:0]  str_stack [4097];
    int          stk_cnt, bit_buf, bit_cnt, code_w, next_free, prev_code;
    int          cur_row, cur_col;
    int unsigned pix_done;
    logic [1:0]  fin_state;

    // Stream builder state
    longint      enc_acc;
    int          enc_bits, enc_free, enc_width, enc_resid;
    bit          enc_after_clear;
    int          code_plan [$];
    logic [2:0]  last_status;

    stim_entry_t stim_q [$];
    out_item_t   pixel_q [$];
    out_item_t   cur_want;
    int          gap_left, stall_left, fails;
    logic        nv, ncv;
    bit          quiet;

    function automatic int eff_size();
        if (dec_min_size < 2) return 2;
        if (dec_min_size > 8) return 8;
        return int'(dec_min_size);
    endfunction

    function automatic int clear_code();
        return 1 << eff_size();
    endfunction

    function automatic void restart_codes();
        code_w = eff_size() + 1;
        next_free = clear_code() + 2;
        prev_code = clear_code();
    endfunction

    function automatic int advance_row(int r);
        int h;
        h = dec_height;
        if (dec_interlace == 0) return (r + 1) & 16'hFFFF;
        if ((r & 7) == 0) begin
            r += 8;
            if (r >= h) begin
                r = 4;
                if (r >= h) begin
                    r = 2;
                    if (r >= h) r = 1;
                end
            end
        end else if ((r & 3) == 0) begin
            r += 8;
            if (r >= h) begin
                r = 2;
                if (r >= h) r = 1;
            end
        end else if ((r & 1) == 0) begin
            r += 4;
            if (r >= h) r = 1;
        end else begin
            r += 2;
        end
        return r & 16'hFFFF;
    endfunction

    // Unwind one data code onto the stack and grow the dictionary
    function automatic bit unwind_code(int code);
        int cc, first, oc, sc, fc;
        bit rep;
        cc = clear_code();
        first = cc + 2;
        sc = 0;
        rep = 0;
        if (code > next_free) return 0;
        if (code == next_free) begin
            if (prev_code == cc) return 0;
            rep = 1;
            sc = 1;
            oc = prev_code;
        end else begin
            oc = code;
        end
        while (oc >= first) begin
            if (oc >= 4096 || sc >= 4097) return 0;
            str_stack[sc] = dict_suffix[oc];
            sc++;
            oc = int'(dict_prefix[oc]);
        end
        if (sc >= 4097) return 0;
        fc = oc & 255;
        str_stack[sc] = fc[7:0];
        sc++;
        if (rep) str_stack[0] = fc[7:0];
        if (prev_code != cc) begin
            if (next_free < 4096) begin
                dict_prefix[next_free] = prev_code[11:0];
                dict_suffix[next_free] = fc[7:0];
            end
            next_free++;
            if (next_free >= 4096) return 0;
            if (next_free >= (1 << code_w) && code_w < 12) code_w++;
        end
        prev_code = code;
        stk_cnt = sc;
        return 1;
    endfunction

    function automatic out_item_t decode_item(logic op, logic [7:0] b);
        out_item_t o;
        longint    total;
        int        code, cc;
        o = '0;
        total = longint'(dec_width) * longint'(dec_height);
        if (fin_state == FIN_RUNNING && longint'(pix_done) >= total) begin
            fin_state = FIN_DONE;
            stk_cnt = 0;
        end
        if (fin_state != FIN_RUNNING) begin
            o.status = (fin_state == FIN_DONE) ? ST_DONE : ST_ERROR;
            return o;
        end
        if (op == OP_PUSH) begin
            if (bit_cnt > 16) begin
                o.status = ST_REJECTED;
                return o;
            end
            bit_buf = (bit_buf | (int'(b) << bit_cnt)) & 24'hFFFFFF;
            bit_cnt += 8;
            o.status = ST_BYTE_TAKEN;
            return o;
        end
        while (stk_cnt == 0) begin
            if (bit_cnt < code_w) begin
                o.status = ST_NEED_DATA;
                return o;
            end
            code = bit_buf & ((1 << code_w) - 1);
            bit_buf = bit_buf >> code_w;
            bit_cnt -= code_w;
            cc = clear_code();
            if (code == cc + 1) begin
                fin_state = FIN_DONE;
                o.status = ST_DONE;
                return o;
            end
            if (code == cc) begin
                restart_codes();
                continue;
            end
            if (!unwind_code(code)) begin
                fin_state = FIN_ERROR;
                stk_cnt = 0;
                o.status = ST_ERROR;
                return o;
            end
        end
        stk_cnt--;
        o.status = ST_PIXEL;
        o.pixel_value = str_stack[stk_cnt];
        o.pixel_row = cur_row[15:0];
        o.pixel_column = cur_col[15:0];
        o.byte_offset = 34'(longint'(cur_row) * longint'(dec_stride) + longint'(cur_col));
        pix_done++;
        if (longint'(pix_done) >= total) begin
            o.is_last = 1'b1;
            fin_state = FIN_DONE;
            stk_cnt = 0;
        end else begin
            cur_col++;
            if (cur_col >= dec_width) begin
                cur_col = 0;
                cur_row = advance_row(cur_row);
            end
            cur_col &= 16'hFFFF;
        end
        return o;
    endfunction

    task automatic add_item(logic op, logic [7:0] b);
        stim_entry_t e;
        e.is_cfg = 0;
        e.cfg = '0;
        e.item.op = op;
        e.item.data_byte = b;
        e.want = decode_item(op, b);
        last_status = e.want.status;
        stim_q = {stim_q, e};
    endtask

    task automatic add_cfg(logic [2:0] idx, int v);
        stim_entry_t e;
        e.is_cfg = 1;
        e.cfg.index = idx;
        e.cfg.data = v[17:0];
        e.item = '0;
        e.want = '0;
        case (idx)
            REG_MIN_CODE_SIZE: begin
                dec_min_size = v[3:0];
                restart_codes();
            end
            REG_IMAGE_WIDTH:  dec_width = v & 16'hFFFF;
            REG_IMAGE_HEIGHT: dec_height = v & 16'hFFFF;
            REG_ROW_STRIDE:   dec_stride = v & 18'h3FFFF;
            REG_INTERLACED:   dec_interlace = v & 1;
            default: ;
        endcase
        stim_q = {stim_q, e};
    endtask

    // Pick the next code that keeps the stream well formed
    function automatic int pick_code();
        int clr, c, r;
        clr = clear_code();
        if (code_plan.size() > 0) begin
            c = code_plan.pop_front();
        end else if (enc_free >= 4000) begin
            c = clr;
        end else if (enc_after_clear) begin
            c = $urandom_range(0, clr - 1);
        end else begin
            r = $urandom_range(0, 99);
            if (r < 4) c = clr;
            else if (r < 45) c = $urandom_range(0, clr - 1);
            else if (r < 85 && enc_free > clr + 2) c = $urandom_range(clr + 2, enc_free - 1);
            else c = enc_free;
        end
        // Leftover bits in the decoder are zeros and form the low bits of this code
        if (enc_resid > 0) c = c & ~((1 << enc_resid) - 1);
        return c;
    endfunction

    task automatic emit_code(int c);
        int w;
        w = enc_width;
        enc_acc = enc_acc | (longint'(c >> enc_resid) << enc_bits);
        enc_bits += w - enc_resid;
        enc_resid = 0;
        if (c == clear_code()) begin
            enc_width = eff_size() + 1;
            enc_free = clear_code() + 2;
            enc_after_clear = 1;
        end else if (enc_after_clear) begin
            enc_after_clear = 0;
        end else begin
            enc_free++;
            if (enc_free >= (1 << enc_width) && enc_width < 12) enc_width++;
        end
    endtask

    task automatic push_stream_byte();
        add_item(OP_PUSH, enc_acc[7:0]);
        enc_acc = enc_acc >> 8;
        enc_bits -= 8;
    endtask

    task automatic run_phase(int n);
        int cnt, r;
        cnt = 0;
        while (cnt < n && fin_state == FIN_RUNNING) begin
            r = $urandom_range(0, 99);
            if (bit_cnt > 16 && r < 8) begin
                add_item(OP_PUSH, 8'($urandom_range(0, 255)));
            end else if (r < 50 || bit_cnt > 16) begin
                add_item(OP_DRAIN, 8'($urandom_range(0, 255)));
            end else begin
                while (enc_bits < 8) emit_code(pick_code());
                push_stream_byte();
            end
            cnt++;
        end
    endtask

    // Drain until the decoder asks for data or the frame ends
    task automatic drain_out();
        do
            add_item(OP_DRAIN, 8'($urandom_range(0, 255)));
        while (last_status == ST_PIXEL && fin_state == FIN_RUNNING);
    endtask

    // Pad and send what is built, then empty the pixel stack
    task automatic settle();
        if (enc_bits % 8 != 0) enc_bits += 8 - enc_bits % 8;
        while (enc_bits > 0 && fin_state == FIN_RUNNING) begin
            if (bit_cnt <= 16) push_stream_byte();
            else add_item(OP_DRAIN, 8'($urandom_range(0, 255)));
        end
        drain_out();
    endtask

    // Align the stream builder with the decoder after register writes
    task automatic resync();
        drain_out();
        enc_free = next_free;
        enc_width = code_w;
        enc_after_clear = (prev_code == clear_code());
        enc_resid = bit_cnt;
        enc_acc = 0;
        enc_bits = 0;
    endtask

    task automatic check_field(string name, longint want, longint got);
        if (want != got) begin
            $error("%s expected %0d actual %0d", name, want, got);
            fails++;
        end
    endtask

    // Driver: feed input items and register writes from the pending queue
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            in_if.valid <= 1'b0;
            in_if.payload <= '0;
            cfg_if.valid <= 1'b0;
            cfg_if.payload <= '0;
            gap_left = 0;
        end else begin
            nv = in_if.valid;
            ncv = cfg_if.valid;
            if (in_if.valid && in_if.ready) begin
                pixel_q = {pixel_q, cur_want};
                nv = 1'b0;
            end
            if (cfg_if.valid && cfg_if.ready) ncv = 1'b0;
            if (!nv && !ncv) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (stim_q.size() > 0) begin
                    if (stim_q[0].is_cfg) begin
                        // hold register writes until every result is back
                        if (pixel_q.size() == 0) begin
                            cfg_if.payload <= stim_q[0].cfg;
                            ncv = 1'b1;
                            void'(stim_q.pop_front());
                        end
                    end else begin
                        in_if.payload <= stim_q[0].item;
                        cur_want = stim_q[0].want;
                        nv = 1'b1;
                        void'(stim_q.pop_front());
                        if (!quiet && $urandom_range(0, 3) == 0) gap_left = $urandom_range(1, 5);
                    end
                end
            end
            in_if.valid <= nv;
            cfg_if.valid <= ncv;
        end
    end

    // Monitor: stall the output at random and compare each result
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            out_if.ready <= 1'b0;
            stall_left = 0;
        end else begin
            if (out_if.valid && out_if.ready) begin
                out_item_t got, want;
                got = out_if.payload;
                if (pixel_q.size() == 0) begin
                    $error("unexpected item with status %0d", got.status);
                    fails++;
                end else begin
                    want = pixel_q.pop_front();
                    check_field("status", want.status, got.status);
                    check_field("pixel_value", want.pixel_value, got.pixel_value);
                    check_field("pixel_row", want.pixel_row, got.pixel_row);
                    check_field("pixel_column", want.pixel_column, got.pixel_column);
                    check_field("byte_offset", want.byte_offset, got.byte_offset);
                    check_field("is_last", want.is_last, got.is_last);
                end
            end
            quiet = (stim_q.size() < 150);
            if (stall_left > 0) begin
                stall_left--;
                out_if.ready <= 1'b0;
            end else begin
                out_if.ready <= 1'b1;
                if (!quiet && $urandom_range(0, 5) == 0) stall_left = $urandom_range(1, 5);
            end
        end
    end

    initial begin
        int clr, extra, w;
        fails = 0;
        quiet = 0;
        dec_min_size = 4'd8;
        dec_width = 1;
        dec_height = 1;
        dec_stride = 1;
        dec_interlace = 0;
        stk_cnt = 0;
        bit_buf = 0;
        bit_cnt = 0;
        restart_codes();
        cur_row = 0;
        cur_col = 0;
        pix_done = 0;
        fin_state = FIN_RUNNING;

        // Phase one: size extremes written, then a directed code sequence
        add_cfg(REG_MIN_CODE_SIZE, 15);
        add_cfg(REG_MIN_CODE_SIZE, 0);
        add_cfg(REG_MIN_CODE_SIZE, 8);
        add_cfg(REG_IMAGE_WIDTH, $urandom_range(1, 16));
        add_cfg(REG_IMAGE_HEIGHT, 65535);
        add_cfg(REG_ROW_STRIDE, $urandom_range(1, 262143));
        add_cfg(REG_INTERLACED, 0);
        resync();
        add_item(OP_DRAIN, 8'hFF);
        clr = clear_code();
        // clear, both literal extremes, a dictionary entry, the KwKwK case, clear again
        code_plan = '{clr, 0, 255, clr + 2, clr + 4, clr, 255, 0, clr + 2};
        run_phase(300);

        settle();
        add_cfg(REG_IMAGE_WIDTH, 65535);
        add_cfg(REG_ROW_STRIDE, 262143);
        add_cfg(REG_INTERLACED, 1);
        resync();
        run_phase(300);

        settle();
        add_cfg(REG_MIN_CODE_SIZE, 2);
        add_cfg(REG_IMAGE_WIDTH, 1);
        add_cfg(REG_ROW_STRIDE, 1);
        resync();
        run_phase(300);

        settle();
        add_cfg(REG_MIN_CODE_SIZE, $urandom_range(0, 15));
        add_cfg(REG_IMAGE_WIDTH, $urandom_range(2, 8));
        add_cfg(REG_IMAGE_HEIGHT, $urandom_range(2000, 65535));
        add_cfg(REG_ROW_STRIDE, $urandom_range(1, 262143));
        add_cfg(REG_INTERLACED, $urandom_range(0, 1));
        resync();
        run_phase(300);

        // Last phase ends the frame by the end code or by the pixel count
        settle();
        add_cfg(REG_MIN_CODE_SIZE, $urandom_range(2, 8));
        if ($urandom_range(0, 1) == 0) begin
            resync();
            run_phase(350);
            settle();
            resync();
            emit_code(clear_code() + 1);
            settle();
        end else begin
            w = $urandom_range(1, 3);
            extra = $urandom_range(30, 80);
            add_cfg(REG_IMAGE_WIDTH, w);
            add_cfg(REG_IMAGE_HEIGHT, (int'(pix_done) + extra) / w + 1);
            add_cfg(REG_INTERLACED, 1);
            resync();
            run_phase(2000);
        end
        repeat (6) add_item(logic'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        do
            @(posedge clk);
        while (stim_q.size() > 0 || in_if.valid || cfg_if.valid || pixel_q.size() > 0);
        repeat (50) @(posedge clk);
        if (fails == 0 && pixel_q.size() == 0)
            $display("gif_lzw_decoder_unit: match");
        else
            $display("gif_lzw_decoder_unit: mismatch");
        $finish;
    end

    initial begin
        #5000000;
        $display("gif_lzw_decoder_unit: mismatch");
        $finish;
    end

endmodule
